// ===== rtl/core/ism_pkg.sv =====
`default_nettype none
package ism_pkg;

	localparam int MAX_RANGES   = 32;
	localparam int CHANNEL_BITS = 16;
	localparam int TOTAL_BITS   = CHANNEL_BITS + 1;

	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [TOTAL_BITS-1:0]   total_t;

	// sequencer states
	typedef enum logic {
		ST_LOAD,
		ST_MERGE
	} state_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic  ins_en;
		logic  shift_en;
		chan_t s;
		chan_t e;
	} cell_ctl_t;

	// merge unit status toward the sequencer
	typedef struct packed {
		logic have_cur;
		logic pop;
		logic done;
	} merge_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ism_cell.sv =====
`default_nettype none
module ism_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ism_pkg::cell_ctl_t ctl,
	input  logic              prev_ins,
	input  logic              prev_valid,
	input  ism_pkg::chan_t    prev_start,
	input  ism_pkg::chan_t    prev_end,
	input  logic              next_valid,
	input  ism_pkg::chan_t    next_start,
	input  ism_pkg::chan_t    next_end,
	output logic              ins,
	output logic              valid,
	output ism_pkg::chan_t    start_val,
	output ism_pkg::chan_t    end_val
);
	import ism_pkg::*;

	logic  valid_q;
	chan_t start_q;
	chan_t end_q;
	logic  goes_before;

	// new range sorts ahead of this entry: start ascending, end descending
	always_comb begin
		if (ctl.s != start_q) begin
			goes_before = (ctl.s < start_q);
		end else begin
			goes_before = (ctl.e > end_q);
		end
		ins = !valid_q || goes_before;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift_en) begin
			valid_q <= next_valid;
		end else if (ctl.ins_en && ins) begin
			valid_q <= valid_q | prev_valid;
		end
	end

	// payload: insert takes the left neighbor or the new range, drain takes the right
	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			start_q <= next_start;
			end_q   <= next_end;
		end else if (ctl.ins_en && ins) begin
			if (prev_ins) begin
				start_q <= prev_start;
				end_q   <= prev_end;
			end else begin
				start_q <= ctl.s;
				end_q   <= ctl.e;
			end
		end
	end

	assign valid     = valid_q;
	assign start_val = start_q;
	assign end_val   = end_q;

endmodule
`default_nettype wire

// ===== rtl/core/ism_merge.sv =====
`default_nettype none
module ism_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 active,
	input  logic                 head_valid,
	input  ism_pkg::chan_t       head_start,
	input  ism_pkg::chan_t       head_end,
	input  logic                 overflow,
	input  logic                 out_stall,
	output ism_pkg::merge_stat_t stat,
	output logic                 out_valid,
	output ism_pkg::chan_t       merged_start,
	output ism_pkg::chan_t       merged_end,
	output ism_pkg::total_t      selected_total,
	output logic                 overflowed,
	output logic                 last_merged
);
	import ism_pkg::*;

	logic   have_q;
	chan_t  cs_q;
	chan_t  ce_q;
	total_t total_q;
	logic   out_valid_q;
	chan_t  out_start_q;
	chan_t  out_end_q;
	total_t out_total_q;
	logic   out_ovf_q;
	logic   out_last_q;

	logic   adv;
	logic   pop;
	logic   done;
	logic   joins;
	logic   emit;
	total_t len;
	total_t total_next;

	// one stored range consumed per step while the output has room
	always_comb begin
		adv        = active && !(out_valid_q && out_stall);
		pop        = adv && head_valid;
		done       = adv && !head_valid;
		joins      = ({1'b0, head_start} <= ({1'b0, ce_q} + total_t'(1)));
		emit       = have_q && ((pop && !joins) || done);
		len        = {1'b0, ce_q} - {1'b0, cs_q} + total_t'(1);
		total_next = total_q + len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			total_q <= '0;
		end else if (done) begin
			have_q  <= 1'b0;
			total_q <= '0;
		end else if (pop) begin
			have_q <= 1'b1;
			if (emit) begin
				total_q <= total_next;
			end
		end
	end

	// current merged range
	always_ff @(posedge clk) begin
		if (pop) begin
			if (!have_q || !joins) begin
				cs_q <= head_start;
				ce_q <= head_end;
			end else if (head_end > ce_q) begin
				ce_q <= head_end;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_start_q <= cs_q;
			out_end_q   <= ce_q;
			out_total_q <= total_next;
			out_ovf_q   <= overflow;
			out_last_q  <= done;
		end
	end

	assign stat.have_cur  = have_q;
	assign stat.pop       = pop;
	assign stat.done      = done;
	assign out_valid      = out_valid_q;
	assign merged_start   = out_start_q;
	assign merged_end     = out_end_q;
	assign selected_total = out_total_q;
	assign overflowed     = out_ovf_q;
	assign last_merged    = out_last_q;

	// a stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("result overwritten while stalled");

	// nothing is consumed outside a merge pass
	a_idle_no_cur: assert property (@(posedge clk) disable iff (!arst_n)
		!active |-> (!pop && !done))
		else $error("merge step outside merge pass");

	// final result closes the current range
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!have_q && total_q == '0))
		else $error("merge state not cleared after final result");

endmodule
`default_nettype wire

// ===== rtl/core/interval_sort_merge.sv =====
// Interval sort and merge.
// Input channel (in_valid / in_stall): one inclusive range per transfer,
// range_start/range_end, with last_range on the final range of a set. A
// reversed range is stored with its bounds swapped. While loading, a range
// is taken every cycle; each one is placed in sorted order by a row of
// cells that compare it against their own entry in parallel and shift.
// Ranges arriving with the row full are dropped and overflowed is raised.
// After the transfer carrying last_range, in_stall goes high and the row
// drains into the merge unit, one stored range per cycle while no result
// is stalled, then a closing step for the final range; input resumes
// once the drain is done.
// Output channel (out_valid / out_stall): one merged range per transfer
// with the running selected_total; last_merged marks the end of the set.
// A stalled result holds and the drain pauses with it.
// Reset (arst_n low) empties the row, clears the overflow flag and the
// output register; the block then accepts ranges at once.
`default_nettype none
module interval_sort_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ism_pkg::chan_t  range_start,
	input  ism_pkg::chan_t  range_end,
	input  logic            last_range,
	output logic            out_valid,
	input  logic            out_stall,
	output ism_pkg::chan_t  merged_start,
	output ism_pkg::chan_t  merged_end,
	output ism_pkg::total_t selected_total,
	output logic            overflowed,
	output logic            last_merged
);
	import ism_pkg::*;

	state_t      state_q;
	state_t      state_d;
	logic        overflow_q;
	logic        accept;
	logic        full;
	logic        merge_active;
	cell_ctl_t   ctl;
	merge_stat_t mstat;

	logic [MAX_RANGES-1:0] c_ins;
	logic [MAX_RANGES-1:0] c_valid;
	chan_t                 c_start [MAX_RANGES];
	chan_t                 c_end   [MAX_RANGES];

	assign accept = in_valid && !in_stall;
	assign full   = c_valid[MAX_RANGES-1];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && last_range) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				if (mstat.done) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// state outputs
	always_comb begin
		unique case (state_q)
			ST_LOAD: begin
				in_stall     = 1'b0;
				merge_active = 1'b0;
			end
			ST_MERGE: begin
				in_stall     = 1'b1;
				merge_active = 1'b1;
			end
			default: begin
				in_stall     = 1'b1;
				merge_active = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// overflow flag lives for one set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
		end else if (mstat.done) begin
			overflow_q <= 1'b0;
		end else if (accept && full) begin
			overflow_q <= 1'b1;
		end
	end

	// broadcast to the row, bounds ordered
	always_comb begin
		ctl.ins_en   = accept && !full;
		ctl.shift_en = mstat.pop;
		if (range_start > range_end) begin
			ctl.s = range_end;
			ctl.e = range_start;
		end else begin
			ctl.s = range_start;
			ctl.e = range_end;
		end
	end

	// row of sorting cells; cell 0 is the head
	for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
		logic  p_ins;
		logic  p_valid;
		chan_t p_start;
		chan_t p_end;
		logic  n_valid;
		chan_t n_start;
		chan_t n_end;

		if (k == 0) begin : g_head
			assign p_ins   = 1'b0;
			assign p_valid = 1'b1;
			assign p_start = ctl.s;
			assign p_end   = ctl.e;
		end else begin : g_body
			assign p_ins   = c_ins[k-1];
			assign p_valid = c_valid[k-1];
			assign p_start = c_start[k-1];
			assign p_end   = c_end[k-1];
		end

		if (k == MAX_RANGES - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_start = ctl.s;
			assign n_end   = ctl.e;
		end else begin : g_mid
			assign n_valid = c_valid[k+1];
			assign n_start = c_start[k+1];
			assign n_end   = c_end[k+1];
		end

		ism_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_ins   (p_ins),
			.prev_valid (p_valid),
			.prev_start (p_start),
			.prev_end   (p_end),
			.next_valid (n_valid),
			.next_start (n_start),
			.next_end   (n_end),
			.ins        (c_ins[k]),
			.valid      (c_valid[k]),
			.start_val  (c_start[k]),
			.end_val    (c_end[k])
		);
	end

	ism_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.active         (merge_active),
		.head_valid     (c_valid[0]),
		.head_start     (c_start[0]),
		.head_end       (c_end[0]),
		.overflow       (overflow_q),
		.out_stall      (out_stall),
		.stat           (mstat),
		.out_valid      (out_valid),
		.merged_start   (merged_start),
		.merged_end     (merged_end),
		.selected_total (selected_total),
		.overflowed     (overflowed),
		.last_merged    (last_merged)
	);

	// occupied cells always form a prefix of the row
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(c_valid & (c_valid + MAX_RANGES'(1))) == '0)
		else $error("occupied cells not contiguous");

	// end of a pass leaves the row empty and the flag clear
	a_pass_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.done |=> (!c_valid[0] && !overflow_q && state_q == ST_LOAD))
		else $error("row not empty after merge pass");

	// no merge context is held while loading
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !mstat.have_cur)
		else $error("merge range held while loading");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES   = 8;
	localparam int PRESSURE_HOLD  = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_TAIL     = 40;

	// one range offered on the input channel
	typedef struct {
		ism_pkg::chan_t lo;
		ism_pkg::chan_t hi;
		logic           fin;
	} range_item_t;

	// one merged range as the block should report it
	typedef struct {
		ism_pkg::chan_t  lo;
		ism_pkg::chan_t  hi;
		ism_pkg::total_t total;
		logic            ovf;
		logic            fin;
	} merged_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	ism_pkg::chan_t  range_start = '0;
	ism_pkg::chan_t  range_end = '0;
	logic            last_range = 1'b0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	ism_pkg::chan_t  merged_start;
	ism_pkg::chan_t  merged_end;
	ism_pkg::total_t selected_total;
	logic            overflowed;
	logic            last_merged;

	interval_sort_merge u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.range_start    (range_start),
		.range_end      (range_end),
		.last_range     (last_range),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.merged_start   (merged_start),
		.merged_end     (merged_end),
		.selected_total (selected_total),
		.overflowed     (overflowed),
		.last_merged    (last_merged)
	);

	always #5 clk = ~clk;

	range_item_t range_q[$];
	merged_t     merged_q[$];

	// shadow of the sorted range store
	ism_pkg::chan_t set_lo[ism_pkg::MAX_RANGES];
	ism_pkg::chan_t set_hi[ism_pkg::MAX_RANGES];
	int             set_cnt = 0;
	logic           set_overflow = 1'b0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	logic hold_arm   = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left  = 0;
	int   idle_cycles = 0;

	int errors          = 0;
	int ranges_sent     = 0;
	int sets_closed     = 0;
	int overflow_sets   = 0;
	int results_checked = 0;

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		errors++;
	endtask

	// sorted insert: start ascending, end descending, equal keys go after
	function automatic void store_range(ism_pkg::chan_t lo, ism_pkg::chan_t hi);
		int pos;
		if (set_cnt >= ism_pkg::MAX_RANGES) begin
			set_overflow = 1'b1;
			return;
		end
		pos = set_cnt;
		for (int k = 0; k < set_cnt; k++) begin
			if (lo < set_lo[k] || (lo == set_lo[k] && hi > set_hi[k])) begin
				pos = k;
				break;
			end
		end
		for (int k = set_cnt; k > pos; k--) begin
			set_lo[k] = set_lo[k-1];
			set_hi[k] = set_hi[k-1];
		end
		set_lo[pos] = lo;
		set_hi[pos] = hi;
		set_cnt++;
	endfunction

	// walk the store, join overlapping/adjacent ranges, queue the results
	function automatic void merge_set();
		ism_pkg::chan_t  cur_lo;
		ism_pkg::chan_t  cur_hi;
		ism_pkg::total_t run_total;
		merged_t         m;
		run_total = '0;
		if (set_cnt != 0) begin
			cur_lo = set_lo[0];
			cur_hi = set_hi[0];
			for (int k = 1; k < set_cnt; k++) begin
				if ({1'b0, set_lo[k]} <= {1'b0, cur_hi} + ism_pkg::total_t'(1)) begin
					if (set_hi[k] > cur_hi)
						cur_hi = set_hi[k];
				end else begin
					run_total = run_total + {1'b0, cur_hi} - {1'b0, cur_lo}
						+ ism_pkg::total_t'(1);
					m = '{cur_lo, cur_hi, run_total, set_overflow, 1'b0};
					merged_q = {merged_q, m};
					cur_lo = set_lo[k];
					cur_hi = set_hi[k];
				end
			end
			run_total = run_total + {1'b0, cur_hi} - {1'b0, cur_lo}
				+ ism_pkg::total_t'(1);
			m = '{cur_lo, cur_hi, run_total, set_overflow, 1'b1};
			merged_q = {merged_q, m};
		end
		if (set_overflow)
			overflow_sets++;
		sets_closed++;
		set_cnt = 0;
		set_overflow = 1'b0;
	endfunction

	function automatic void absorb_range(ism_pkg::chan_t s, ism_pkg::chan_t e, logic fin);
		if (s > e)
			store_range(e, s);
		else
			store_range(s, e);
		if (fin)
			merge_set();
	endfunction

	// input side: offer queued ranges, hold while stalled, predict on transfer
	always @(posedge clk or negedge arst_n) begin : range_driver
		range_item_t nxt;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			range_start <= '0;
			range_end   <= '0;
			last_range  <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_range(range_start, range_end, last_range);
				ranges_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (range_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = range_q.pop_front();
					in_valid    <= 1'b1;
					range_start <= nxt.lo;
					range_end   <= nxt.hi;
					last_range  <= nxt.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check each transfer, stall at random or for the long hold
	always @(posedge clk or negedge arst_n) begin : merged_monitor
		merged_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			hold_left  <= 0;
			hold_taken <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (merged_q.size() == 0) begin
					report_mismatch($sformatf("result %0d..%0d with nothing pending",
						merged_start, merged_end));
				end else begin
					want = merged_q.pop_front();
					if (merged_start !== want.lo)
						report_mismatch($sformatf("merged_start got %0d want %0d",
							merged_start, want.lo));
					if (merged_end !== want.hi)
						report_mismatch($sformatf("merged_end got %0d want %0d",
							merged_end, want.hi));
					if (selected_total !== want.total)
						report_mismatch($sformatf("selected_total got %0d want %0d",
							selected_total, want.total));
					if (overflowed !== want.ovf)
						report_mismatch($sformatf("overflowed got %b want %b",
							overflowed, want.ovf));
					if (last_merged !== want.fin)
						report_mismatch($sformatf("last_merged got %b want %b",
							last_merged, want.fin));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (hold_arm && !hold_taken) begin
				hold_left  <= PRESSURE_HOLD;
				hold_taken <= 1'b1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// watchdog: too long without a transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
				$display("interval_sort_merge verification failed");
				$finish;
			end
		end
	end

	task automatic add_range(ism_pkg::chan_t lo, ism_pkg::chan_t hi, logic fin);
		range_item_t it;
		it = '{lo, hi, fin};
		range_q = {range_q, it};
	endtask

	// one set of ranges clustered around a random base, last flag on the end
	task automatic queue_set(int n);
		ism_pkg::chan_t base;
		ism_pkg::chan_t lo;
		ism_pkg::chan_t hi;
		ism_pkg::chan_t tmp;
		int spread;
		base = ism_pkg::chan_t'($urandom);
		case ($urandom_range(0, 3))
			0: spread = 16;
			1: spread = 256;
			2: spread = 4096;
			default: spread = 65535;
		endcase
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				lo = ism_pkg::chan_t'($urandom);
				hi = ism_pkg::chan_t'($urandom);
			end else begin
				lo = ism_pkg::chan_t'(base + $urandom_range(0, spread));
				hi = ism_pkg::chan_t'(lo + $urandom_range(0, spread / 4));
				if ($urandom_range(0, 7) == 0) begin
					tmp = lo;
					lo  = hi;
					hi  = tmp;
				end
			end
			add_range(lo, hi, i == n - 1);
		end
	endtask

	// mostly small sets, now and then a full store or an overflowing one
	task automatic queue_sets(int budget);
		int used;
		int r;
		int n;
		used = 0;
		while (used < budget) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				n = ism_pkg::MAX_RANGES;
			else if (r == 1)
				n = $urandom_range(ism_pkg::MAX_RANGES + 1, ism_pkg::MAX_RANGES + 4);
			else
				n = $urandom_range(1, 12);
			queue_set(n);
			used += n;
		end
	endtask

	// sampled away from the rising edge so driver updates are settled
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (range_q.size() != 0 || in_valid || merged_q.size() != 0);
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, reversed bounds, single-range sets
		add_range(16'h0000, 16'h0000, 1'b1);
		add_range(16'hFFFF, 16'hFFFF, 1'b1);
		add_range(16'h0000, 16'hFFFF, 1'b1);
		add_range(16'hFFFF, 16'h0000, 1'b1);
		add_range(16'd500, 16'd100, 1'b1);
		// adjacent, nested, duplicate, touching end/start, bit-boundary neighbors
		add_range(16'd10, 16'd20, 1'b0);
		add_range(16'd21, 16'd30, 1'b0);
		add_range(16'd5, 16'd8, 1'b0);
		add_range(16'd25, 16'd27, 1'b0);
		add_range(16'd10, 16'd20, 1'b0);
		add_range(16'd30, 16'd40, 1'b0);
		add_range(16'd50, 16'd60, 1'b0);
		add_range(16'd12, 16'd12, 1'b0);
		add_range(16'h8000, 16'h8000, 1'b0);
		add_range(16'h7FFF, 16'h7FFF, 1'b0);
		add_range(16'hAAAA, 16'h5555, 1'b1);
		// single channels joined only through sort order
		add_range(16'd1, 16'd1, 1'b0);
		add_range(16'd3, 16'd3, 1'b0);
		add_range(16'd2, 16'd2, 1'b1);
		// top channel, where end + 1 needs the extra bit
		add_range(16'd65530, 16'd65535, 1'b0);
		add_range(16'd65535, 16'd65535, 1'b1);
		wait_quiet();

		// random sets under each idle mix
		send_idle_pct = 0;  recv_stall_pct = 0;
		queue_sets(90);
		wait_quiet();
		send_idle_pct = 81; recv_stall_pct = 0;
		queue_sets(90);
		wait_quiet();
		send_idle_pct = 0;  recv_stall_pct = 81;
		queue_sets(90);
		wait_quiet();
		send_idle_pct = 20; recv_stall_pct = 20;
		queue_sets(90);
		wait_quiet();

		// long receiver hold while the sender keeps offering: overflow, full, small
		send_idle_pct = 0;  recv_stall_pct = 0;
		hold_arm = 1'b1;
		queue_set(ism_pkg::MAX_RANGES + 2);
		queue_set(ism_pkg::MAX_RANGES);
		queue_set(9);
		wait_quiet();

		repeat (DRAIN_TAIL) @(posedge clk);
		if (merged_q.size() != 0)
			report_mismatch($sformatf("%0d merged results never arrived", merged_q.size()));
		$display("Sent %0d ranges in %0d sets (%0d over capacity); checked %0d merged results",
			ranges_sent, sets_closed, overflow_sets, results_checked);
		$display("Traffic mixes: free flow, sparse input, heavy output stall, light both, long hold");
		if (errors == 0)
			$display("interval_sort_merge verification clean");
		else
			$display("interval_sort_merge verification failed");
		$finish;
	end

endmodule
`default_nettype wire
